/* sv/csvp_pkg.sv */
// Shared constants, types and helper functions for the CSV triple parser.
package csvp_pkg;

  // Line buffer size in bytes; a line is dropped once it fills all but one byte
  localparam int LINE_BUFFER_BYTES = 64;
  localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BUFFER_BYTES - 1);

  localparam int VAL_W = 16;

  // Field phase codes
  localparam logic [1:0] PH_SPACE  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // Character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // One parsed line
  typedef struct packed {
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] z;
  } res_t;

  // Signed value of a field from magnitude and sign, modulo 2^16
  function automatic logic [VAL_W-1:0] field_val(input logic [VAL_W-1:0] mag,
                                                input logic neg);
    field_val = neg ? (VAL_W'(0) - mag) : mag;
  endfunction

endpackage

/* sv/csvp_parser.sv */
// Line parser: field state, accumulator and saved fields, updated once per byte.
module csvp_parser import csvp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] byte_data,
  input  logic       advance,
  output logic       emit,
  output res_t       res
);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [1:0]       fnum_r, fnum_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [VAL_W-1:0] first_r, first_nxt;
  logic [VAL_W-1:0] second_r, second_nxt;

  logic [LEN_W-1:0] b_len;
  logic [1:0]       b_fnum, b_phase;
  logic             b_neg;
  logic [VAL_W-1:0] b_acc;
  logic             is_eol, is_sep, is_digit, is_ws, is_sign;
  logic [VAL_W-1:0] digit_val, acc_x10;

  // character classes
  assign is_eol    = (byte_data == CH_LF) || (byte_data == CH_CR);
  assign is_sep    = (byte_data == CH_COMMA) || (byte_data == CH_NUL);
  assign is_digit  = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
  assign is_ws     = (byte_data == CH_SPACE) || (byte_data == CH_TAB) ||
                     (byte_data == CH_VT) || (byte_data == CH_FF);
  assign is_sign   = (byte_data == CH_PLUS) || (byte_data == CH_MINUS);
  assign digit_val = VAL_W'(byte_data[3:0]);

  // line state after the buffer-limit restart
  always_comb begin
    if (len_r == LEN_LAST) begin
      b_len   = '0;
      b_fnum  = 2'd0;
      b_phase = PH_SPACE;
      b_neg   = 1'b0;
      b_acc   = '0;
    end else begin
      b_len   = len_r;
      b_fnum  = fnum_r;
      b_phase = phase_r;
      b_neg   = neg_r;
      b_acc   = acc_r;
    end
  end

  assign acc_x10 = (b_acc << 3) + (b_acc << 1) + digit_val;

  // result of the line that ends with this byte
  assign emit  = byte_valid && is_eol && (b_fnum >= 2'd2);
  assign res.x = first_r;
  assign res.y = second_r;
  assign res.z = field_val(b_acc, b_neg);

  // next state
  always_comb begin
    len_nxt    = b_len + LEN_W'(1);
    fnum_nxt   = b_fnum;
    phase_nxt  = b_phase;
    neg_nxt    = b_neg;
    acc_nxt    = b_acc;
    first_nxt  = first_r;
    second_nxt = second_r;
    if (is_eol) begin
      len_nxt   = '0;
      fnum_nxt  = 2'd0;
      phase_nxt = PH_SPACE;
      neg_nxt   = 1'b0;
      acc_nxt   = '0;
    end else if (b_fnum != 2'd3) begin
      if (is_sep) begin
        // close a field; the third one stays in the accumulator as z
        if (b_fnum == 2'd0) begin
          first_nxt = field_val(b_acc, b_neg);
        end else if (b_fnum == 2'd1) begin
          second_nxt = field_val(b_acc, b_neg);
        end
        if (b_fnum != 2'd2) begin
          phase_nxt = PH_SPACE;
          neg_nxt   = 1'b0;
          acc_nxt   = '0;
        end
        fnum_nxt = b_fnum + 2'd1;
      end else begin
        unique case (b_phase)
          PH_SPACE: begin
            if (is_ws) begin
              phase_nxt = PH_SPACE;
            end else if (is_sign) begin
              neg_nxt   = (byte_data == CH_MINUS);
              phase_nxt = PH_DIGITS;
            end else if (is_digit) begin
              acc_nxt   = digit_val;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              acc_nxt = acc_x10;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            phase_nxt = b_phase;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      fnum_r   <= 2'd0;
      phase_r  <= PH_SPACE;
      neg_r    <= 1'b0;
      acc_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
    end else if (byte_valid && advance) begin
      len_r    <= len_nxt;
      fnum_r   <= fnum_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      acc_r    <= acc_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

/* sv/csvp_out_reg.sv */
// Result register holding one parsed line until the receiver takes it.
module csvp_out_reg import csvp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t load_res,
  input  logic out_stall,
  output logic out_valid,
  output res_t out_res
);

  logic valid_r, valid_nxt;
  res_t res_r;

  // valid: set on load, cleared once the word is taken
  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* sv/ascii_csv_triple_parser_core.sv */
// Top level of the ASCII CSV triple parser: input register, parser and result register.
//
// Takes one received byte per word and parses lines "x,y,z" ending at CR or LF.
// Each field is read with atoi rules (leading blanks, optional sign, digits up
// to the first non-digit) and wraps to 16-bit two's complement; comma or NUL
// separates fields and fields past the third are ignored. A line with at least
// three fields gives one result word (x, y, z); shorter lines give nothing.
// A line reaching LINE_BUFFER_BYTES-1 bytes is dropped and parsing restarts with
// the next byte. Throughput is one byte per clock while the input is not stalled: a byte is
// held in the input register, the parser updates its state from it in that same cycle, and
// a result appears on the output in the next cycle. The input stalls only when a
// line end would produce a result while the previous result is still held.
module ascii_csv_triple_parser_core import csvp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [15:0] out_x_value,
  output logic signed [15:0] out_y_value,
  output logic signed [15:0] out_z_value
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       emit, advance, in_take;
  res_t       line_res, out_res;

  // input register advances unless a result would meet a held output
  assign advance  = !(emit && out_valid && out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // parser
  csvp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (s1_valid_r),
    .byte_data  (s1_byte_r),
    .advance    (advance),
    .emit       (emit),
    .res        (line_res)
  );

  // result register
  csvp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit && advance),
    .load_res  (line_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_x_value = out_res.x;
  assign out_y_value = out_res.y;
  assign out_z_value = out_res.z;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the ASCII CSV triple parser: directed table, then random lines.
`timescale 1ns / 1ps

module tb_top;
  import csvp_pkg::*;

  localparam int unsigned RAND_BYTES  = 750;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam logic [7:0]  FILL_CHAR   = 8'h23;  // '#', pads a line up to the buffer limit
  localparam logic [7:0]  NUL_MARK    = 8'h7E;  // '~' in the table text stands for NUL

  // How the last byte of a directed row is checked
  typedef enum {BY_MODEL, WANT_NONE, WANT_LINE} line_check_t;

  typedef struct {
    int          pad;
    string       text;
    line_check_t how;
    int          x;
    int          y;
    int          z;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_x_value;
  logic signed [15:0] out_y_value;
  logic signed [15:0] out_z_value;

  // Parsed lines still to come out of the block, oldest first
  res_t line_q [$];
  res_t want_line;
  int unsigned mismatches = 0;

  // Stimulus pacing shared by sender and receiver
  bit quiet = 1'b0;
  int unsigned hold_kicks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  logic [7:0] blanks [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

  // Line parser state, tracked alongside the block
  int unsigned ln_len = 0;
  logic [1:0]  ln_fields = 2'd0;
  logic [1:0]  fld_phase = PH_SPACE;
  bit          fld_neg = 1'b0;
  logic [15:0] fld_acc = 16'd0;
  logic [15:0] x_held = 16'd0;
  logic [15:0] y_held = 16'd0;

  ascii_csv_triple_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x_value(out_x_value),
    .out_y_value(out_y_value),
    .out_z_value(out_z_value)
  );

  always #10 clk = ~clk;

  function automatic void clear_field();
    fld_phase = PH_SPACE;
    fld_neg   = 1'b0;
    fld_acc   = 16'd0;
  endfunction

  function automatic void clear_line();
    ln_len    = 0;
    ln_fields = 2'd0;
    clear_field();
  endfunction

  // Signed value of the field in progress, mod 2^16
  function automatic logic [15:0] field_now();
    return fld_neg ? 16'(16'd0 - fld_acc) : fld_acc;
  endfunction

  // Advance the parser by one byte; returns 1 when a complete line comes out
  function automatic bit parse_byte(input logic [7:0] c, output res_t r);
    bit got;
    bit is_digit;
    logic [15:0] dig;
    got = 1'b0;
    r = '0;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    dig = 16'(c - CH_ZERO);
    // full buffer: drop the line and start again with this byte
    if (ln_len >= LINE_BUFFER_BYTES - 1) clear_line();
    ln_len++;
    if (c == CH_LF || c == CH_CR) begin
      if (ln_fields >= 2'd2) begin
        got = 1'b1;
        r.x = x_held;
        r.y = y_held;
        r.z = field_now();
      end
      clear_line();
    end else if (ln_fields != 2'd3) begin
      if (c == CH_COMMA || c == CH_NUL) begin
        // third separator leaves accumulator and sign standing as z
        if (ln_fields == 2'd0) begin
          x_held = field_now();
          clear_field();
        end else if (ln_fields == 2'd1) begin
          y_held = field_now();
          clear_field();
        end
        ln_fields++;
      end else if (fld_phase == PH_SPACE) begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          fld_neg   = (c == CH_MINUS);
          fld_phase = PH_DIGITS;
        end else if (is_digit) begin
          fld_acc   = dig;
          fld_phase = PH_DIGITS;
        end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)) begin
          fld_phase = PH_DONE;
        end
      end else if (fld_phase == PH_DIGITS) begin
        if (is_digit) fld_acc = 16'(fld_acc * 16'd10 + dig);
        else fld_phase = PH_DONE;
      end
    end
    return got;
  endfunction

  // Offer one byte word after a random gap, wait for it to be taken, then track it
  task automatic drive_byte(input logic [7:0] b, output bit hit, output res_t r);
    while (!quiet && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    hit = parse_byte(b, r);
  endtask

  task automatic send_checked(input logic [7:0] b);
    bit hit;
    res_t r;
    drive_byte(b, hit, r);
    if (hit) line_q.push_back(r);
  endtask

  // Sender goes quiet until every pending line has come out or DRAIN_LIMIT is reached
  task automatic drain_lines();
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (line_q.size() != 0 && n < DRAIN_LIMIT);
  endtask

  // One random line: mostly well-formed triples, some short, long, overlong or noise
  task automatic make_line(ref logic [7:0] chars [$]);
    int kind;
    int nf;
    int nd;
    chars.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 20)) chars.push_back(8'($urandom_range(255)));
    end else if (kind < 14) begin
      // may run past the buffer limit
      repeat ($urandom_range(55, 75)) begin
        if ($urandom_range(3) == 0) chars.push_back(CH_COMMA);
        else chars.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
    end else begin
      nf = (kind < 24) ? $urandom_range(1, 2) : ((kind < 32) ? $urandom_range(4, 5) : 3);
      for (int f = 0; f < nf; f++) begin
        if (f != 0) chars.push_back(($urandom_range(15) == 0) ? CH_NUL : CH_COMMA);
        repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
          chars.push_back(blanks[$urandom_range(3)]);
        case ($urandom_range(9))
          0, 1, 2: chars.push_back(CH_MINUS);
          3: chars.push_back(CH_PLUS);
          default: ;
        endcase
        nd = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(0, 5);
        repeat (nd) chars.push_back(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(7) == 0) chars.push_back(8'($urandom_range(255)));
      end
    end
    case ($urandom_range(3))
      0: chars.push_back(CH_CR);
      1: begin
        chars.push_back(CH_CR);
        chars.push_back(CH_LF);
      end
      default: chars.push_back(CH_LF);
    endcase
  endtask

  // Receiver: random stalls, one long hold-off counted here, none while quiet
  always @(posedge clk) begin
    if (hold_seen != hold_kicks) begin
      hold_seen <= hold_kicks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && !quiet && ($urandom_range(99) < 34);
    end
  end

  // Compare each result word taken with the oldest pending line
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (line_q.size() == 0) begin
        $error("unexpected line: x=%0d y=%0d z=%0d", out_x_value, out_y_value, out_z_value);
        mismatches++;
      end else begin
        want_line = line_q.pop_front();
        if (out_x_value !== want_line.x) begin
          $error("x_value: expected %0d, got %0d", want_line.x, out_x_value);
          mismatches++;
        end
        if (out_y_value !== want_line.y) begin
          $error("y_value: expected %0d, got %0d", want_line.y, out_y_value);
          mismatches++;
        end
        if (out_z_value !== want_line.z) begin
          $error("z_value: expected %0d, got %0d", want_line.z, out_z_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    logic [7:0] chars [$];
    logic [7:0] ch;
    bit hit;
    res_t r;
    int last;
    int unsigned sent;
    bit held;
    bit paused;

    dir_rows = '{
      '{0,  "\n",                              WANT_NONE, 0, 0, 0},
      '{0,  "1,2,3\n",                         WANT_LINE, 1, 2, 3},
      '{0,  "32767,-32768,0\n",                WANT_LINE, 32767, -32768, 0},
      '{0,  "65535,32768,-1\n",                WANT_LINE, -1, -32768, -1},
      '{0,  "65536,100000,-65537\n",           WANT_LINE, 0, -31072, -1},
      '{0,  " \011\013\014+12,  -7 , 9x\015",  WANT_LINE, 12, -7, 9},
      '{0,  "4,5\n",                           WANT_NONE, 0, 0, 0},
      '{0,  "4\n",                             WANT_NONE, 0, 0, 0},
      '{0,  "1,2,3,4,5\n",                     WANT_LINE, 1, 2, 3},
      '{0,  "1,2,3,\n",                        WANT_LINE, 1, 2, 3},
      '{0,  "~~\n",                            WANT_LINE, 0, 0, 0},
      '{0,  "1~2~3\015",                       WANT_LINE, 1, 2, 3},
      '{0,  "--5,+-3,-+\n",                    WANT_LINE, 0, 0, 0},
      '{0,  "abc,  ,-\n",                      WANT_LINE, 0, 0, 0},
      '{0,  "1 2,3\n",                         WANT_NONE, 0, 0, 0},
      '{63, "7,8,9\n",                         WANT_LINE, 7, 8, 9},
      '{62, "1,2,3\n",                         BY_MODEL,  0, 0, 0},
      '{61, "5,6,7\n",                         BY_MODEL,  0, 0, 0},
      '{63, "\n",                              BY_MODEL,  0, 0, 0},
      '{0,  "\015\n",                          WANT_NONE, 0, 0, 0},
      '{0,  "-32768,-32769,99999\015",         BY_MODEL,  0, 0, 0},
      '{0,  "00012,0,0009\n",                  WANT_LINE, 12, 0, 9},
      '{0,  "\377\200,1,2\n",                  WANT_LINE, 0, 1, 2},
      '{0,  "1,2,3\n9,8,7\n",                  BY_MODEL,  0, 0, 0}
    };
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; the row's final byte carries the typed-in check if it has one
    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].pad) send_checked(FILL_CHAR);
      last = dir_rows[i].text.len() - 1;
      for (int k = 0; k <= last; k++) begin
        ch = dir_rows[i].text[k];
        if (ch == NUL_MARK) ch = CH_NUL;
        if (k != last || dir_rows[i].how == BY_MODEL) begin
          send_checked(ch);
        end else begin
          drive_byte(ch, hit, r);
          if (dir_rows[i].how == WANT_LINE) begin
            r.x = 16'(dir_rows[i].x);
            r.y = 16'(dir_rows[i].y);
            r.z = 16'(dir_rows[i].z);
            line_q.push_back(r);
          end
        end
      end
    end
    drain_lines();

    // Random lines, with a quiet stretch, a receiver hold-off and one full drain
    while (sent < RAND_BYTES) begin
      make_line(chars);
      quiet = (sent >= 150 && sent < 300);
      if (!held && sent >= 400) begin
        hold_kicks++;
        held = 1'b1;
      end
      if (!paused && sent >= 600) begin
        drain_lines();
        paused = 1'b1;
      end
      foreach (chars[k]) send_checked(chars[k]);
      sent += chars.size();
    end
    quiet = 1'b0;

    drain_lines();
    repeat (10) @(posedge clk);
    if (line_q.size() != 0) begin
      $error("%0d expected lines never came out", line_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ascii_csv_triple_parser_core verification clean");
    end else begin
      $display("ascii_csv_triple_parser_core verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("ascii_csv_triple_parser_core verification failed");
    $finish;
  end

endmodule
